### rtl/core/flow_controlled_byte_fifo_core_defines.svh
`ifndef FLOW_CONTROLLED_BYTE_FIFO_CORE_DEFINES_SVH
`define FLOW_CONTROLLED_BYTE_FIFO_CORE_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define FCBF_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define FCBF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/fcbf_pkg.sv
package fcbf_pkg;

   localparam int unsigned MODE_W   = 3;
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned OFFSET_W = 10;
   localparam int unsigned CAP_W    = 11;
   localparam int unsigned TOTAL_W  = 32;

   localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

   localparam logic [MODE_W-1:0] MODE_WRITE = 3'd0;
   localparam logic [MODE_W-1:0] MODE_READ  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_PEEK  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_POP   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_END   = 3'd4;

   typedef logic [MODE_W-1:0]   mode_type;
   typedef logic [BYTE_W-1:0]   byte_type;
   typedef logic [OFFSET_W-1:0] offset_type;
   typedef logic [CAP_W-1:0]    count_type;
   typedef logic [TOTAL_W-1:0]  total_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic accept;   // take the request beat and update the queue
      logic load;     // load the response register
   } cmd_type;

endpackage

### rtl/core/fcbf_channels.sv
interface fcbf_req_if;
   logic                   valid;
   logic                   ready;
   fcbf_pkg::mode_type     mode;
   fcbf_pkg::byte_type     write_byte;
   fcbf_pkg::offset_type   peek_offset;

   modport source (output valid, output mode, output write_byte, output peek_offset,
                   input ready);
   modport sink   (input valid, input mode, input write_byte, input peek_offset,
                   output ready);
endinterface

interface fcbf_rsp_if;
   logic                   valid;
   logic                   ready;
   fcbf_pkg::byte_type     read_byte;
   logic                   read_valid;
   logic                   write_accepted;
   fcbf_pkg::count_type    occupancy;
   fcbf_pkg::count_type    space_left;
   fcbf_pkg::total_type    total_written;
   fcbf_pkg::total_type    total_read;
   logic                   input_done;
   logic                   end_of_stream;

   modport source (output valid, output read_byte, output read_valid,
                   output write_accepted, output occupancy, output space_left,
                   output total_written, output total_read, output input_done,
                   output end_of_stream, input ready);
   modport sink   (input valid, input read_byte, input read_valid,
                   input write_accepted, input occupancy, input space_left,
                   input total_written, input total_read, input input_done,
                   input end_of_stream, output ready);
endinterface

interface fcbf_csr_if;
   logic                   valid;
   logic                   ready;
   fcbf_pkg::count_type    data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/fcbf_ctrl.sv
module fcbf_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output fcbf_pkg::cmd_type cmd
);
   import fcbf_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // hold until the response register is free or being drained
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

### rtl/core/fcbf_datapath.sv
module fcbf_datapath #(
   parameter int unsigned DEPTH = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  fcbf_pkg::cmd_type    cmd,
   input  fcbf_pkg::mode_type   mode,
   input  fcbf_pkg::byte_type   write_byte,
   input  fcbf_pkg::offset_type peek_offset,
   input  logic                 csr_write,
   input  fcbf_pkg::count_type  csr_data,
   output fcbf_pkg::byte_type   read_byte,
   output logic                 read_valid,
   output logic                 write_accepted,
   output fcbf_pkg::count_type  occupancy,
   output fcbf_pkg::count_type  space_left,
   output fcbf_pkg::total_type  total_written,
   output fcbf_pkg::total_type  total_read,
   output logic                 input_done,
   output logic                 end_of_stream
);
   import fcbf_pkg::*;

   localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned SUM_W  = ((ADDR_W > CAP_W) ? ADDR_W : CAP_W) + 1;

   // Advance a slot index around the ring; off never exceeds DEPTH when it matters
   function automatic logic [ADDR_W-1:0] wrap(input logic [ADDR_W-1:0] base,
                                              input count_type off);
      logic [SUM_W-1:0] s;
      s = SUM_W'(base) + SUM_W'(off);
      if (s >= SUM_W'(DEPTH)) begin
         s = s - SUM_W'(DEPTH);
      end
      return s[ADDR_W-1:0];
   endfunction

   byte_type mem [DEPTH];

   logic [ADDR_W-1:0] head_ff, head_in;
   count_type         count_ff, count_in;
   total_type         wtotal_ff, wtotal_in;
   total_type         rtotal_ff, rtotal_in;
   logic              ended_ff, ended_in;
   count_type         cap_ff;

   byte_type          mem_q_ff;
   logic              pend_rvalid_ff, pend_rvalid_in;
   logic              pend_wacc_ff, pend_wacc_in;

   byte_type          read_byte_ff;
   logic              read_valid_ff, write_accepted_ff;
   count_type         occupancy_ff, space_left_ff;
   total_type         total_written_ff, total_read_ff;
   logic              input_done_ff, end_of_stream_ff;

   count_type         cap_eff;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic              wr_en;

   assign cap_eff = (32'(cap_ff) > 32'(DEPTH)) ? CAP_W'(DEPTH) : cap_ff;
   assign wr_addr = wrap(head_ff, count_ff);
   assign rd_addr = (mode == MODE_PEEK) ? wrap(head_ff, CAP_W'(peek_offset)) : head_ff;

   always_comb begin
      head_in        = head_ff;
      count_in       = count_ff;
      wtotal_in      = wtotal_ff;
      rtotal_in      = rtotal_ff;
      ended_in       = ended_ff;
      pend_rvalid_in = 1'b0;
      pend_wacc_in   = 1'b0;
      wr_en          = 1'b0;
      case (mode)
         MODE_WRITE: begin
            if (count_ff < cap_eff) begin
               wr_en        = 1'b1;
               count_in     = count_ff + 1'b1;
               wtotal_in    = wtotal_ff + 1'b1;
               pend_wacc_in = 1'b1;
            end
         end
         MODE_READ, MODE_POP: begin
            // an empty queue drops the request without counting it
            if (count_ff != '0) begin
               pend_rvalid_in = (mode == MODE_READ);
               head_in        = wrap(head_ff, CAP_W'(1));
               count_in       = count_ff - 1'b1;
               rtotal_in      = rtotal_ff + 1'b1;
            end
         end
         MODE_PEEK: begin
            pend_rvalid_in = (CAP_W'(peek_offset) < count_ff);
         end
         MODE_END: begin
            ended_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         if (wr_en) begin
            mem[wr_addr] <= write_byte;
         end
         mem_q_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= '0;
         count_ff  <= '0;
         wtotal_ff <= '0;
         rtotal_ff <= '0;
         ended_ff  <= 1'b0;
         cap_ff    <= CAP_RESET;
      end else begin
         if (cmd.accept) begin
            head_ff   <= head_in;
            count_ff  <= count_in;
            wtotal_ff <= wtotal_in;
            rtotal_ff <= rtotal_in;
            ended_ff  <= ended_in;
         end
         if (csr_write) begin
            cap_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         pend_rvalid_ff <= pend_rvalid_in;
         pend_wacc_ff   <= pend_wacc_in;
      end
      // queue state already holds the post-operation values here
      if (cmd.load) begin
         read_byte_ff      <= pend_rvalid_ff ? mem_q_ff : '0;
         read_valid_ff     <= pend_rvalid_ff;
         write_accepted_ff <= pend_wacc_ff;
         occupancy_ff      <= count_ff;
         space_left_ff     <= (count_ff < cap_eff) ? (cap_eff - count_ff) : '0;
         total_written_ff  <= wtotal_ff;
         total_read_ff     <= rtotal_ff;
         input_done_ff     <= ended_ff;
         end_of_stream_ff  <= ended_ff && (count_ff == '0);
      end
   end

   assign read_byte      = read_byte_ff;
   assign read_valid     = read_valid_ff;
   assign write_accepted = write_accepted_ff;
   assign occupancy      = occupancy_ff;
   assign space_left     = space_left_ff;
   assign total_written  = total_written_ff;
   assign total_read     = total_read_ff;
   assign input_done     = input_done_ff;
   assign end_of_stream  = end_of_stream_ff;

endmodule

### rtl/core/flow_controlled_byte_fifo_core.sv
// Channel   Role   Handshake        Beat contents
// req_ch    sink   valid / ready    mode, write_byte, peek_offset
// rsp_ch    source valid / ready    read_byte ... end_of_stream (status after the op)
// csr_ch    sink   valid / ready    data: capacity, always ready
//
// Each request is taken in the IDLE state, which updates the queue and issues the
// registered byte-store read; the EXEC state then loads the response register.
// A new request is taken while a response still waits, but the load stalls until
// the response register drains, so a held rsp_ch.ready stalls req_ch after one beat.
// Synchronous reset empties the queue, clears totals and the ended flag, and sets
// capacity to 1024; the byte store itself is not cleared.
module flow_controlled_byte_fifo_core #(
   parameter int unsigned DEPTH = 1024
) (
   input  logic              clock,
   input  logic              reset,
   fcbf_req_if.sink          req_ch,
   fcbf_rsp_if.source        rsp_ch,
   fcbf_csr_if.sink          csr_ch
);
   import fcbf_pkg::*;
`include "flow_controlled_byte_fifo_core_defines.svh"

   cmd_type cmd;

   assign csr_ch.ready = 1'b1;

   fcbf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   fcbf_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .mode           (req_ch.mode),
      .write_byte     (req_ch.write_byte),
      .peek_offset    (req_ch.peek_offset),
      .csr_write      (csr_ch.valid && csr_ch.ready),
      .csr_data       (csr_ch.data),
      .read_byte      (rsp_ch.read_byte),
      .read_valid     (rsp_ch.read_valid),
      .write_accepted (rsp_ch.write_accepted),
      .occupancy      (rsp_ch.occupancy),
      .space_left     (rsp_ch.space_left),
      .total_written  (rsp_ch.total_written),
      .total_read     (rsp_ch.total_read),
      .input_done     (rsp_ch.input_done),
      .end_of_stream  (rsp_ch.end_of_stream)
   );

   `FCBF_ASSERT_NEXT(a_one_in_flight, clock, reset, cmd.accept, !req_ch.ready, "request taken while busy")
   `FCBF_ASSERT_NEXT(a_load_shows, clock, reset, cmd.load, rsp_ch.valid, "loaded response not shown")
   `FCBF_ASSERT_SAME(a_read_xor_write, clock, reset, rsp_ch.valid && rsp_ch.read_valid, !rsp_ch.write_accepted, "read and write in one beat")
   `FCBF_ASSERT_SAME(a_eos, clock, reset, rsp_ch.valid && rsp_ch.end_of_stream, rsp_ch.input_done && (rsp_ch.occupancy == '0), "end of stream inconsistent")

endmodule

### sim/flow_controlled_byte_fifo_core_test.sv
module flow_controlled_byte_fifo_core_test;
   import fcbf_pkg::*;

   localparam int unsigned QUEUE_DEPTH = 1024;
   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned HOLD_CYCLES = 300;
   localparam int unsigned IDLE_PCT    = 21;

   // Mode codes with no operation behind them
   localparam mode_type MODE_SPARE5 = 3'd5;
   localparam mode_type MODE_SPARE6 = 3'd6;
   localparam mode_type MODE_SPARE7 = 3'd7;

   typedef struct {
      byte_type  read_byte;
      logic      read_valid;
      logic      write_accepted;
      count_type occupancy;
      count_type space_left;
      total_type total_written;
      total_type total_read;
      logic      input_done;
      logic      end_of_stream;
   } fifo_status_type;

   logic clock = 1'b0;
   logic reset;

   fcbf_req_if req_ch();
   fcbf_rsp_if rsp_ch();
   fcbf_csr_if csr_ch();

   flow_controlled_byte_fifo_core #(.DEPTH(QUEUE_DEPTH)) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #5 clock = ~clock;

   // Queue model state
   byte_type        held_bytes [QUEUE_DEPTH];
   offset_type      head_slot        = '0;
   count_type       fill_count       = '0;
   total_type       written_sum      = '0;
   total_type       read_sum         = '0;
   logic            ended_seen       = 1'b0;
   count_type       capacity_setting = CAP_RESET;
   fifo_status_type status_expected [$];

   int          error_count   = 0;
   int          hold_requests = 0;
   bit          idling_on     = 1'b1;
   int unsigned cycle_count   = 0;

   function automatic fifo_status_type apply_byte_op(mode_type op, byte_type wbyte,
                                                     offset_type off);
      fifo_status_type st;
      count_type       limit;
      offset_type      slot;
      st = '{default: '0};
      limit = (capacity_setting > count_type'(QUEUE_DEPTH)) ? count_type'(QUEUE_DEPTH)
                                                            : capacity_setting;
      case (op)
         MODE_WRITE: begin
            if (fill_count < limit) begin
               slot = head_slot + fill_count[OFFSET_W-1:0];
               held_bytes[slot] = wbyte;
               fill_count++;
               written_sum++;
               st.write_accepted = 1'b1;
            end
         end
         MODE_READ, MODE_POP: begin
            if (fill_count != 0) begin
               if (op == MODE_READ) begin
                  st.read_byte  = held_bytes[head_slot];
                  st.read_valid = 1'b1;
               end
               head_slot = head_slot + 1'b1;
               fill_count--;
               read_sum++;
            end
         end
         MODE_PEEK: begin
            if (count_type'(off) < fill_count) begin
               slot = head_slot + off;
               st.read_byte  = held_bytes[slot];
               st.read_valid = 1'b1;
            end
         end
         MODE_END: ended_seen = 1'b1;
         default: ;
      endcase
      st.occupancy     = fill_count;
      st.space_left    = (fill_count < limit) ? limit - fill_count : '0;
      st.total_written = written_sum;
      st.total_read    = read_sum;
      st.input_done    = ended_seen;
      st.end_of_stream = ended_seen && (fill_count == 0);
      return st;
   endfunction

   task automatic report_mismatch(string what);
      $display("ERROR cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
   endtask

   task automatic send_byte_op(mode_type op, byte_type wbyte, offset_type off);
      while (idling_on && $urandom_range(0, 99) < IDLE_PCT) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.mode        <= op;
      req_ch.write_byte  <= wbyte;
      req_ch.peek_offset <= off;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      status_expected.push_back(apply_byte_op(op, wbyte, off));
   endtask

   // Write only once every outstanding beat has come back
   task automatic write_capacity(count_type value);
      req_ch.valid <= 1'b0;
      while (status_expected.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= value;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      csr_ch.valid <= 1'b0;
      capacity_setting = value;
   endtask

   // Mostly offsets inside the held bytes, now and then anywhere
   function automatic offset_type pick_peek_offset();
      if (fill_count != 0 && $urandom_range(0, 9) < 7)
         return offset_type'($urandom_range(0, fill_count - 1));
      return offset_type'($urandom);
   endfunction

   task automatic send_random_op(int write_pct);
      int         r;
      mode_type   op;
      offset_type off;
      off = offset_type'($urandom);
      r = $urandom_range(0, 99);
      if (r < write_pct) begin
         op = MODE_WRITE;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 35)      op = MODE_READ;
         else if (r < 55) op = MODE_POP;
         else if (r < 85) begin
            op  = MODE_PEEK;
            off = pick_peek_offset();
         end
         else if (r < 92) op = MODE_END;
         else             op = MODE_SPARE5 + mode_type'($urandom_range(0, 2));
      end
      send_byte_op(op, byte_type'($urandom), off);
   endtask

   task automatic test_basic_ops();
      send_byte_op(MODE_PEEK,   8'h00, 10'd0);
      send_byte_op(MODE_READ,   8'hFF, 10'h3FF);
      send_byte_op(MODE_POP,    8'h00, 10'd0);
      send_byte_op(MODE_WRITE,  8'h00, 10'h3FF);
      send_byte_op(MODE_WRITE,  8'hFF, 10'd0);
      send_byte_op(MODE_WRITE,  8'hA5, 10'd0);
      send_byte_op(MODE_PEEK,   8'h00, 10'd0);
      send_byte_op(MODE_PEEK,   8'h00, 10'd2);
      send_byte_op(MODE_PEEK,   8'h00, 10'd3);
      send_byte_op(MODE_PEEK,   8'h00, 10'h3FF);
      send_byte_op(MODE_READ,   8'h00, 10'd0);
      send_byte_op(MODE_POP,    8'h00, 10'd0);
      send_byte_op(MODE_SPARE5, 8'h5A, 10'd1);
      send_byte_op(MODE_SPARE6, 8'h5A, 10'd1);
      send_byte_op(MODE_SPARE7, 8'h5A, 10'd1);
      send_byte_op(MODE_END,    8'h00, 10'd0);
      send_byte_op(MODE_END,    8'h00, 10'd0);
      send_byte_op(MODE_WRITE,  8'h5A, 10'd0);
      send_byte_op(MODE_READ,   8'h00, 10'd0);
      send_byte_op(MODE_READ,   8'h00, 10'd0);
      send_byte_op(MODE_READ,   8'h00, 10'd0);
   endtask

   task automatic test_capacity_limits();
      write_capacity(11'd0);
      send_byte_op(MODE_WRITE, 8'h11, 10'd0);
      write_capacity(11'd1);
      send_byte_op(MODE_WRITE, 8'h3C, 10'd0);
      send_byte_op(MODE_WRITE, 8'h3D, 10'd0);
      write_capacity(11'd3);
      send_byte_op(MODE_WRITE, 8'h3E, 10'd0);
      send_byte_op(MODE_WRITE, 8'h3F, 10'd0);
      send_byte_op(MODE_WRITE, 8'h40, 10'd0);
      // Drop capacity under the occupancy: nothing is lost, writes bounce
      write_capacity(11'd1);
      send_byte_op(MODE_WRITE, 8'h41, 10'd0);
      send_byte_op(MODE_READ,  8'h00, 10'd0);
      write_capacity(11'd2047);
      send_byte_op(MODE_WRITE, 8'h42, 10'd0);
      repeat (3) send_byte_op(MODE_READ, 8'h00, 10'd0);
      write_capacity(11'd1024);
      send_byte_op(MODE_WRITE, 8'h43, 10'd0);
      send_byte_op(MODE_READ,  8'h00, 10'd0);
   endtask

   // Hold the response side while requests keep coming so the input stalls
   task automatic test_backpressure();
      hold_requests++;
      repeat (30) send_random_op(60);
   endtask

   task automatic test_random_mix();
      count_type cap;
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0:       cap = 11'd1;
            1:       cap = 11'd2;
            2:       cap = 11'd5;
            3:       cap = count_type'($urandom_range(6, 32));
            4:       cap = count_type'($urandom_range(33, 1024));
            5:       cap = 11'd0;
            6:       cap = count_type'($urandom_range(1025, 2047));
            default: cap = 11'd16;
         endcase
         idling_on = (ph != 3);
         write_capacity(cap);
         repeat (30) send_random_op(ph == 5 ? 30 : 55);
      end
      idling_on = 1'b1;
   endtask

   task automatic test_fill_to_depth();
      write_capacity(11'd2047);
      for (int i = 0; i < QUEUE_DEPTH + 1; i++) begin
         idling_on = (i >= 400);
         if (i % 40 == 39)
            send_byte_op(MODE_PEEK, byte_type'($urandom), pick_peek_offset());
         send_byte_op(MODE_WRITE, byte_type'($urandom), offset_type'($urandom));
      end
      send_byte_op(MODE_PEEK, 8'h00, 10'h3FF);
      send_byte_op(MODE_PEEK, 8'h00, 10'd0);
      // Keep it near full so the tail wraps round the store
      repeat (60) send_random_op(50);
      write_capacity(11'd4);
      repeat (40) send_random_op(40);
   endtask

   initial begin : rsp_ready_driver
      int hold_left;
      int holds_served;
      hold_left    = 0;
      holds_served = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left == 0 && holds_served != hold_requests) begin
            hold_left = HOLD_CYCLES;
            holds_served++;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= !(idling_on && $urandom_range(0, 99) < IDLE_PCT);
         end
      end
   end

   always @(posedge clock) begin : rsp_monitor
      fifo_status_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (status_expected.size() == 0) begin
            report_mismatch("response beat with nothing outstanding");
         end else begin
            want = status_expected.pop_front();
            compare_field("read_byte",      rsp_ch.read_byte,      want.read_byte);
            compare_field("read_valid",     rsp_ch.read_valid,     want.read_valid);
            compare_field("write_accepted", rsp_ch.write_accepted, want.write_accepted);
            compare_field("occupancy",      rsp_ch.occupancy,      want.occupancy);
            compare_field("space_left",     rsp_ch.space_left,     want.space_left);
            compare_field("total_written",  rsp_ch.total_written,  want.total_written);
            compare_field("total_read",     rsp_ch.total_read,     want.total_read);
            compare_field("input_done",     rsp_ch.input_done,     want.input_done);
            compare_field("end_of_stream",  rsp_ch.end_of_stream,  want.end_of_stream);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.mode        <= MODE_WRITE;
      req_ch.write_byte  <= '0;
      req_ch.peek_offset <= '0;
      csr_ch.valid       <= 1'b0;
      csr_ch.data        <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_basic_ops();
      test_capacity_limits();
      test_backpressure();
      test_random_mix();
      test_fill_to_depth();

      req_ch.valid <= 1'b0;
      while (status_expected.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
